### design/mstw_pkg.sv
// shared constants and controller/datapath signal groups for the spanning tree weight block
`timescale 1ns / 1ps
`default_nettype none

package mstw_pkg;

  // graph and store sizes
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;

  // field widths
  localparam int VertW     = $clog2(MaxVertices);
  localparam int VCntW     = $clog2(MaxVertices + 1);
  localparam int EdgeIdxW  = $clog2(MaxEdges);
  localparam int EdgeCntW  = $clog2(MaxEdges + 1);
  localparam int WeightW   = 31;
  localparam int TotalW    = 37;
  localparam int ActionW   = 2;
  localparam int CfgW      = 7;
  localparam int EntryW    = 2 * VertW + WeightW;

  localparam logic [WeightW-1:0] InfWeight = {WeightW{1'b1}};
  localparam logic [CfgW-1:0] VertexCountReset = CfgW'(MaxVertices);

  // action codes
  localparam logic [ActionW-1:0] ActClear = 2'd0;
  localparam logic [ActionW-1:0] ActAdd   = 2'd1;
  localparam logic [ActionW-1:0] ActRun   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic add;
    logic run_init;
    logic scan_init;
    logic scan_run;
    logic pick;
    logic relax_run;
  } mstw_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic relax_done;
  } mstw_status_t;

endpackage

`default_nettype wire

### design/mstw_ctrl.sv
// sequencing state machine for clear, add and run items
`timescale 1ns / 1ps
`default_nettype none

module mstw_ctrl import mstw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [ActionW-1:0]  action_i,
  input  wire mstw_status_t        status_i,
  output logic                     busy_o,
  output logic                     done_o,
  output mstw_cmd_t                cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StPick  = 3'd2;
  localparam logic [2:0] StRelax = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (action_i)
            ActClear: cmd_o.clear = 1'b1;
            ActAdd:   cmd_o.add   = 1'b1;
            ActRun: begin
              cmd_o.run_init = 1'b1;
              state_d        = StScan;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = StPick;
        end
      end
      StPick: begin
        if (status_i.found) begin
          cmd_o.pick = 1'b1;
          state_d    = StRelax;
        end else begin
          state_d = StOut;
        end
      end
      StRelax: begin
        cmd_o.relax_run = 1'b1;
        if (status_i.relax_done) begin
          cmd_o.scan_init = 1'b1;
          state_d         = StScan;
        end
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StOut);

endmodule

`default_nettype wire

### design/mstw_datapath.sv
// edge store, distance store, minimum scan and relaxation pipeline
`timescale 1ns / 1ps
`default_nettype none

module mstw_datapath import mstw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mstw_cmd_t           cmd_i,
  output mstw_status_t             status_o,
  input  wire logic [VertW-1:0]    vertex_a_i,
  input  wire logic [VertW-1:0]    vertex_b_i,
  input  wire logic [WeightW-1:0]  edge_weight_i,
  input  wire logic [VertW-1:0]    start_vertex_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  output logic [TotalW-1:0]        tree_weight_o,
  output logic [VCntW-1:0]         vertices_reached_o,
  output logic                     edges_dropped_o
);

  logic [CfgW-1:0]     vcount_q;
  logic [VCntW-1:0]    n_act;
  logic [EdgeCntW-1:0] held_q;
  logic                dropped_q;
  logic                add_ok;

  logic [EntryW-1:0]   edge_mem [MaxEdges];
  logic [EntryW-1:0]   edge_rdata_q;
  logic [WeightW-1:0]  dist_mem [MaxVertices];
  logic [WeightW-1:0]  dist_rdata_q;
  logic [MaxVertices-1:0] dist_valid_q;
  logic [MaxVertices-1:0] in_tree_q;
  logic [VertW-1:0]    dist_raddr;

  logic [VCntW-1:0]    sc_q;
  logic                rv_q;
  logic [VertW-1:0]    ridx_q;
  logic                scan_issue;
  logic [WeightW-1:0]  scan_cur;
  logic                scan_better;
  logic                found_q;
  logic [VertW-1:0]    best_q;
  logic [WeightW-1:0]  best_d_q;

  logic [TotalW-1:0]   total_q;
  logic [VCntW-1:0]    reached_q;

  logic [EdgeCntW-1:0] ec_q;
  logic                relax_issue;
  logic                v1_q;
  logic [VertW-1:0]    e_a, e_b, nbr1;
  logic [WeightW-1:0]  e_w;
  logic                hit1;
  logic                v2_q;
  logic [VertW-1:0]    nbr2_q;
  logic [WeightW-1:0]  w2_q;
  logic [WeightW-1:0]  relax_cur;
  logic                upd;
  logic                wr_v_q;
  logic [VertW-1:0]    wr_addr_q;
  logic [WeightW-1:0]  wr_data_q;
  logic                start_ok;

  // active vertex count, clamped to one through the maximum
  always_comb begin
    if (vcount_q == '0) begin
      n_act = VCntW'(1);
    end else if (32'(vcount_q) > MaxVertices) begin
      n_act = VCntW'(MaxVertices);
    end else begin
      n_act = VCntW'(vcount_q);
    end
  end

  assign add_ok = (VCntW'(vertex_a_i) < n_act) && (VCntW'(vertex_b_i) < n_act)
               && (held_q < EdgeCntW'(MaxEdges));
  assign start_ok = (VCntW'(start_vertex_i) < n_act);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountReset;
    end else if (cfg_valid_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  // edge count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.clear) begin
      held_q    <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.add) begin
      if (add_ok) begin
        held_q <= held_q + EdgeCntW'(1);
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  // edge store
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && add_ok) begin
      edge_mem[held_q[EdgeIdxW-1:0]] <= {vertex_a_i, vertex_b_i, edge_weight_i};
    end
    edge_rdata_q <= edge_mem[ec_q[EdgeIdxW-1:0]];
  end

  // distance store: start entry at run begin, relaxed entries afterwards
  assign dist_raddr = cmd_i.relax_run ? nbr1 : sc_q[VertW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init && start_ok) begin
      dist_mem[start_vertex_i] <= '0;
    end else if (upd) begin
      dist_mem[nbr2_q] <= w2_q;
    end
    dist_rdata_q <= dist_mem[dist_raddr];
  end

  // per-vertex valid and tree membership bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_valid_q <= '0;
      in_tree_q    <= '0;
    end else if (cmd_i.run_init) begin
      // only the start vertex holds a distance at run begin
      dist_valid_q <= {{(MaxVertices-1){1'b0}}, start_ok} << start_vertex_i;
      in_tree_q    <= '0;
    end else begin
      if (upd) begin
        dist_valid_q[nbr2_q] <= 1'b1;
      end
      if (cmd_i.pick) begin
        in_tree_q[best_q] <= 1'b1;
      end
    end
  end

  // minimum scan over vertices, one read per cycle
  assign scan_issue  = cmd_i.scan_run && (sc_q < n_act);
  assign scan_cur    = dist_valid_q[ridx_q] ? dist_rdata_q : InfWeight;
  assign scan_better = rv_q && !in_tree_q[ridx_q] && (scan_cur < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q     <= '0;
      rv_q     <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.run_init || cmd_i.scan_init) begin
      sc_q     <= '0;
      rv_q     <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rv_q <= scan_issue;
      if (scan_issue) begin
        sc_q <= sc_q + VCntW'(1);
      end
      if (scan_better) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= sc_q[VertW-1:0];
    if (cmd_i.run_init || cmd_i.scan_init) begin
      best_d_q <= InfWeight;
    end else if (scan_better) begin
      best_d_q <= scan_cur;
      best_q   <= ridx_q;
    end
  end

  // running total and reached count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      reached_q <= '0;
    end else if (cmd_i.run_init) begin
      total_q   <= '0;
      reached_q <= '0;
    end else if (cmd_i.pick) begin
      total_q   <= total_q + TotalW'(best_d_q);
      reached_q <= reached_q + VCntW'(1);
    end
  end

  // relaxation stage one: edge read back, neighbour of the picked vertex
  assign relax_issue = cmd_i.relax_run && (ec_q < held_q);
  assign e_a  = edge_rdata_q[EntryW-1 -: VertW];
  assign e_b  = edge_rdata_q[WeightW +: VertW];
  assign e_w  = edge_rdata_q[WeightW-1:0];
  assign nbr1 = (e_a == best_q) ? e_b : e_a;
  assign hit1 = v1_q && (VCntW'(e_a) < n_act) && (VCntW'(e_b) < n_act)
             && ((e_a == best_q) || (e_b == best_q));

  // relaxation stage two: compare with forwarded distance and write back
  assign relax_cur = (wr_v_q && (wr_addr_q == nbr2_q)) ? wr_data_q :
                     (dist_valid_q[nbr2_q] ? dist_rdata_q : InfWeight);
  assign upd = v2_q && !in_tree_q[nbr2_q] && (w2_q < relax_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q   <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      wr_v_q <= 1'b0;
    end else if (cmd_i.pick) begin
      ec_q   <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      v1_q   <= relax_issue;
      v2_q   <= hit1;
      wr_v_q <= upd;
      if (relax_issue) begin
        ec_q <= ec_q + EdgeCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nbr2_q    <= nbr1;
    w2_q      <= e_w;
    wr_addr_q <= nbr2_q;
    wr_data_q <= w2_q;
  end

  // status and results
  assign status_o.scan_done  = !scan_issue && !rv_q && (sc_q >= n_act);
  assign status_o.found      = found_q;
  assign status_o.relax_done = (ec_q >= held_q) && !v1_q && !v2_q;

  assign tree_weight_o      = total_q;
  assign vertices_reached_o = reached_q;
  assign edges_dropped_o    = dropped_q;

endmodule

`default_nettype wire

### design/minimum_spanning_tree_weight.sv
// top level of the minimum spanning tree weight block
//
// channel   direction  handshake                 payload
// command   in         start_i, busy_o           action_i, vertex_a_i, vertex_b_i,
//                                                edge_weight_i, start_vertex_i
// result    out        done_o (one-cycle strobe) tree_weight_o, vertices_reached_o,
//                                                edges_dropped_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (vertex count)
//
// clear and add give no result. each round of a run scans the distance memory one
// vertex per cycle and streams the edge memory one edge per cycle through a
// read-compare-write pipeline. reset is asynchronous and active low, no clearing pass
// is needed afterwards. results are shown for one cycle and cannot be stalled;
// busy_o holds off new items.
`timescale 1ns / 1ps
`default_nettype none

module minimum_spanning_tree_weight import mstw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [ActionW-1:0]  action_i,
  input  wire logic [VertW-1:0]    vertex_a_i,
  input  wire logic [VertW-1:0]    vertex_b_i,
  input  wire logic [WeightW-1:0]  edge_weight_i,
  input  wire logic [VertW-1:0]    start_vertex_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  output logic                     done_o,
  output logic [TotalW-1:0]        tree_weight_o,
  output logic [VCntW-1:0]         vertices_reached_o,
  output logic                     edges_dropped_o
);

  mstw_cmd_t    cmd;
  mstw_status_t status;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // controller
  mstw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (status),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  // datapath
  mstw_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .edge_weight_i      (edge_weight_i),
    .start_vertex_i     (start_vertex_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .tree_weight_o      (tree_weight_o),
    .vertices_reached_o (vertices_reached_o),
    .edges_dropped_o    (edges_dropped_o)
  );

endmodule

`default_nettype wire

### sim/tb_minimum_spanning_tree_weight.sv
// testbench for the minimum spanning tree weight block: directed table, random phases, predictor
`timescale 1ns / 1ps

module tb_minimum_spanning_tree_weight;
  import mstw_pkg::*;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int CycleLimit  = 10_000_000;
  localparam int PhaseItems  = 6;
  localparam int SettleTicks = 100;

  typedef struct packed {
    logic [TotalW-1:0] weight;
    logic [VCntW-1:0]  reached;
    logic              dropped;
  } mst_result_t;

  typedef struct packed {
    logic [VertW-1:0]   a;
    logic [VertW-1:0]   b;
    logic [WeightW-1:0] w;
  } edge_t;

  // one row of the directed table: an item or a vertex count write
  typedef struct {
    bit                 is_cfg;
    logic [CfgW-1:0]    cfg;
    logic [ActionW-1:0] action;
    logic [VertW-1:0]   va;
    logic [VertW-1:0]   vb;
    logic [WeightW-1:0] wt;
    logic [VertW-1:0]   root;
    bit                 typed;
    mst_result_t        want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [ActionW-1:0]  action_i;
  logic [VertW-1:0]    vertex_a_i;
  logic [VertW-1:0]    vertex_b_i;
  logic [WeightW-1:0]  edge_weight_i;
  logic [VertW-1:0]    start_vertex_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i;
  logic                done_o;
  logic [TotalW-1:0]   tree_weight_o;
  logic [VCntW-1:0]    vertices_reached_o;
  logic                edges_dropped_o;

  // shadow copy of the block state
  edge_t           edge_mem [MaxEdges];
  int unsigned     edge_total;
  bit              lost_edge;
  logic [CfgW-1:0] vcount;

  mst_result_t     pending_q [$];
  bit              row_typed;
  mst_result_t     row_want;
  int unsigned     mismatches;
  int unsigned     cycle_count;
  row_t            directed [$];

  minimum_spanning_tree_weight dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .action_i           (action_i),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .edge_weight_i      (edge_weight_i),
    .start_vertex_i     (start_vertex_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .tree_weight_o      (tree_weight_o),
    .vertices_reached_o (vertices_reached_o),
    .edges_dropped_o    (edges_dropped_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // register value as the block uses it: 0 acts as 1, above the maximum clamps
  function automatic int unsigned graph_size();
    if (vcount == '0) return 1;
    if (vcount > MaxVertices) return MaxVertices;
    return vcount;
  endfunction

  // prim's algorithm over the shadow edge store, ties to the lower index
  function automatic mst_result_t grow_tree(input logic [VertW-1:0] root);
    int unsigned        n;
    int unsigned        i;
    int unsigned        e;
    int unsigned        pick;
    int unsigned        ea;
    int unsigned        eb;
    logic [WeightW-1:0] pick_d;
    logic [WeightW-1:0] ew;
    logic [WeightW-1:0] tent_d [MaxVertices];
    bit                 joined [MaxVertices];
    mst_result_t        res;
    n = graph_size();
    res.weight  = '0;
    res.reached = '0;
    res.dropped = lost_edge;
    if (root >= n) return res;
    for (i = 0; i < MaxVertices; i++) begin
      tent_d[i] = InfWeight;
      joined[i] = 1'b0;
    end
    tent_d[root] = '0;
    forever begin
      pick   = n;
      pick_d = InfWeight;
      for (i = 0; i < n; i++) begin
        if (!joined[i] && tent_d[i] < pick_d) begin
          pick_d = tent_d[i];
          pick   = i;
        end
      end
      if (pick >= n) break;
      joined[pick] = 1'b1;
      res.reached  = res.reached + 1'b1;
      res.weight   = res.weight + TotalW'(pick_d);
      // relax neighbours, skipping edges outside the current vertex count
      for (e = 0; e < edge_total; e++) begin
        ea = edge_mem[e].a;
        eb = edge_mem[e].b;
        ew = edge_mem[e].w;
        if (ea >= n || eb >= n) continue;
        if (ea == pick && !joined[eb] && ew < tent_d[eb]) tent_d[eb] = ew;
        if (eb == pick && !joined[ea] && ew < tent_d[ea]) tent_d[ea] = ew;
      end
    end
    return res;
  endfunction

  // update the shadow state for one accepted item; returns 1 when a result follows
  function automatic bit apply_item(input logic [ActionW-1:0] act, input logic [VertW-1:0] va,
                                    input logic [VertW-1:0] vb, input logic [WeightW-1:0] wt,
                                    input logic [VertW-1:0] root, output mst_result_t res);
    int unsigned n;
    n   = graph_size();
    res = '0;
    case (act)
      ActClear: begin
        edge_total = 0;
        lost_edge  = 1'b0;
      end
      ActAdd: begin
        if (va >= n || vb >= n || edge_total >= MaxEdges) begin
          lost_edge = 1'b1;
        end else begin
          edge_mem[edge_total] = '{a: va, b: vb, w: wt};
          edge_total++;
        end
      end
      ActRun: begin
        res = grow_tree(root);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // result check, shadow update on accepted items and register writes, timeout
  always @(posedge clk_i) begin : monitor
    mst_result_t got;
    mst_result_t want;
    mst_result_t pred;
    if (rst_ni) begin
      if (done_o) begin
        got = '{tree_weight_o, vertices_reached_o, edges_dropped_o};
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result weight %0d reached %0d",
                                    got.weight, got.reached));
        end else begin
          want = pending_q.pop_front();
          if (got.weight !== want.weight)
            report_mismatch($sformatf("tree_weight %0d, want %0d", got.weight, want.weight));
          if (got.reached !== want.reached)
            report_mismatch($sformatf("vertices_reached %0d, want %0d",
                                      got.reached, want.reached));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("edges_dropped %0b, want %0b", got.dropped, want.dropped));
        end
      end
      if (cfg_valid_i && cfg_ready_o) vcount = cfg_data_i;
      if (start_i && !busy_o) begin
        if (apply_item(action_i, vertex_a_i, vertex_b_i, edge_weight_i, start_vertex_i, pred))
          pending_q = {pending_q, (row_typed ? row_want : pred)};
      end
    end
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // present one item from the falling edge until it is taken
  task automatic send_item(input logic [ActionW-1:0] act, input logic [VertW-1:0] va,
                           input logic [VertW-1:0] vb, input logic [WeightW-1:0] wt,
                           input logic [VertW-1:0] root, input bit typed,
                           input mst_result_t want);
    @(negedge clk_i);
    start_i        <= 1'b1;
    action_i       <= act;
    vertex_a_i     <= va;
    vertex_b_i     <= vb;
    edge_weight_i  <= wt;
    start_vertex_i <= root;
    row_typed      <= typed;
    row_want       <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  // random burst of sender idling
  task automatic sender_gap(input bit allow);
    int unsigned len;
    if (allow && $urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 13);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  endtask

  // block idle: nothing pending, not busy, plus a wait for a trailing add or clear
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [CfgW-1:0] value, input bit allow);
    wait_idle();
    if (allow && $urandom_range(0, 1) == 1) repeat ($urandom_range(1, 13)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // weights lean small for ties, with the extremes and full-width values mixed in
  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return InfWeight;
      2:       return InfWeight - 1'b1;
      3, 4:    return WeightW'($urandom);
      default: return WeightW'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [VertW-1:0] pick_vertex(input int unsigned n);
    return VertW'($urandom_range(0, n - 1));
  endfunction

  // one setting of the register: mostly edges among live vertices and runs
  task automatic random_phase(input logic [CfgW-1:0] setting, input int unsigned items,
                              input bit allow);
    int unsigned n;
    int unsigned sent;
    int unsigned kind;
    logic [VertW-1:0] root;
    n    = 0;
    sent = 0;
    write_vertex_count(setting, allow);
    n = graph_size();
    if ($urandom_range(0, 1) == 1) begin
      send_item(ActClear, '0, '0, '0, '0, 1'b0, '0);
      sent++;
    end
    while (sent < items) begin
      sender_gap(allow);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // ignored action with random fields
        send_item(ActUnused, VertW'($urandom), VertW'($urandom), WeightW'($urandom),
                  VertW'($urandom), 1'b0, '0);
      end else begin
        if (kind == 1) begin
          send_item(ActClear, '0, '0, '0, '0, 1'b0, '0);
        end else if (kind <= 3) begin
          send_item(ActAdd, VertW'($urandom), VertW'($urandom), pick_weight(), '0, 1'b0, '0);
        end else if (kind <= 8) begin
          root = ($urandom_range(0, 4) == 0) ? VertW'($urandom) : pick_vertex(n);
          send_item(ActRun, '0, '0, '0, root, 1'b0, '0);
        end else begin
          send_item(ActAdd, pick_vertex(n), pick_vertex(n), pick_weight(), '0, 1'b0, '0);
        end
        sent++;
      end
    end
    sender_gap(allow);
    send_item(ActRun, '0, '0, '0, pick_vertex(n), 1'b0, '0);
  endtask

  function automatic row_t item_row(input logic [ActionW-1:0] act, input logic [VertW-1:0] va,
                                    input logic [VertW-1:0] vb, input logic [WeightW-1:0] wt,
                                    input logic [VertW-1:0] root);
    row_t r;
    r        = '{default: '0};
    r.action = act;
    r.va     = va;
    r.vb     = vb;
    r.wt     = wt;
    r.root   = root;
    return r;
  endfunction

  function automatic row_t known_run(input logic [VertW-1:0] root, input int unsigned reached,
                                     input bit dropped);
    row_t r;
    r        = item_row(ActRun, '0, '0, '0, root);
    r.typed  = 1'b1;
    r.want   = '{TotalW'(0), VCntW'(reached), dropped};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CfgW-1:0] value);
    row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg    = value;
    return r;
  endfunction

  // append one row to the directed table
  task automatic append_row(input row_t r);
    directed = {directed, r};
  endtask

  // stimulus
  initial begin : stimulus
    logic [CfgW-1:0] settings [10];
    int unsigned k;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    action_i       = ActClear;
    vertex_a_i     = '0;
    vertex_b_i     = '0;
    edge_weight_i  = '0;
    start_vertex_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    row_typed      = 1'b0;
    row_want       = '0;
    mismatches     = 0;
    cycle_count    = 0;
    edge_total     = 0;
    lost_edge      = 1'b0;
    vcount         = VertexCountReset;

    // directed table, register at its reset value first
    append_row(known_run(6'd0, 1, 1'b0));
    append_row(known_run(6'd63, 1, 1'b0));
    append_row(item_row(ActAdd, 6'd0, 6'd1, 31'd5, '0));
    append_row(item_row(ActAdd, 6'd1, 6'd2, 31'd0, '0));
    append_row(item_row(ActAdd, 6'd2, 6'd3, InfWeight, '0));
    append_row(item_row(ActAdd, 6'd3, 6'd3, 31'd7, '0));
    append_row(item_row(ActAdd, 6'd63, 6'd62, InfWeight - 1'b1, '0));
    append_row(item_row(ActAdd, 6'd62, 6'd0, 31'd1, '0));
    append_row(item_row(ActUnused, 6'd63, 6'd63, InfWeight, 6'd63));
    append_row(item_row(ActRun, '0, '0, '0, 6'd0));
    // only an infinite edge and a self loop touch vertex 3
    append_row(known_run(6'd3, 1, 1'b0));
    append_row(item_row(ActRun, '0, '0, '0, 6'd63));
    // shrunk vertex count: endpoints out of range drop, old edges skip
    append_row(cfg_row(CfgW'(4)));
    append_row(item_row(ActAdd, 6'd5, 6'd1, 31'd3, '0));
    append_row(item_row(ActAdd, 6'd1, 6'd4, 31'd3, '0));
    append_row(known_run(6'd4, 0, 1'b1));
    append_row(item_row(ActRun, '0, '0, '0, 6'd0));
    append_row(item_row(ActClear, '0, '0, '0, '0));
    append_row(known_run(6'd0, 1, 1'b0));
    // zero acts as one vertex
    append_row(cfg_row(CfgW'(0)));
    append_row(item_row(ActAdd, 6'd0, 6'd0, 31'd9, '0));
    append_row(item_row(ActAdd, 6'd0, 6'd1, 31'd9, '0));
    append_row(known_run(6'd0, 1, 1'b1));
    append_row(known_run(6'd1, 0, 1'b1));
    // above the maximum clamps
    append_row(cfg_row(CfgW'(127)));
    append_row(known_run(6'd63, 1, 1'b1));
    append_row(item_row(ActClear, '0, '0, '0, '0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < directed.size(); k++) begin
      if (directed[k].is_cfg) begin
        write_vertex_count(directed[k].cfg, 1'b1);
      end else begin
        sender_gap(1'b1);
        send_item(directed[k].action, directed[k].va, directed[k].vb, directed[k].wt,
                  directed[k].root, directed[k].typed, directed[k].want);
      end
    end

    // random phases across register settings, extremes among them
    settings[0] = CfgW'(8);
    settings[1] = CfgW'(64);
    settings[2] = CfgW'(1);
    settings[3] = CfgW'(3);
    settings[4] = CfgW'($urandom_range(2, 20));
    settings[5] = CfgW'(127);
    settings[6] = CfgW'(16);
    settings[7] = CfgW'(0);
    settings[8] = CfgW'(40);
    settings[9] = CfgW'($urandom_range(5, 12));
    for (k = 0; k < 9; k++) random_phase(settings[k], PhaseItems, 1'b1);
    // last stretch runs without idling
    random_phase(settings[9], PhaseItems, 1'b0);

    // drain
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### minimum_spanning_tree_weight.f
design/mstw_pkg.sv
design/mstw_ctrl.sv
design/mstw_datapath.sv
design/minimum_spanning_tree_weight.sv
sim/tb_minimum_spanning_tree_weight.sv
